[src/snpv_pkg.sv]
// Shared types, constants and the character-set function for the 8.3 path validator.
// No dependencies; every other source file imports this package.
package snpv_pkg;

   localparam int CH_W       = 16;
   localparam int LEN_W      = 12;
   localparam int BASE_W     = 4;
   localparam int EXT_W      = 2;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;

   localparam logic [BASE_W-1:0] BASE_MAX  = 4'd8;
   localparam logic [EXT_W-1:0]  EXT_MAX   = 2'd3;
   localparam logic [LEN_W-1:0]  COUNT_MAX = 12'hFFF;
   localparam logic [LEN_W-1:0]  MAX_LEN_RESET = 12'd64;

   localparam logic [CH_W-1:0] CHAR_BACKSLASH = 16'h005C;
   localparam logic [CH_W-1:0] CHAR_DOT       = 16'h002E;
   localparam logic [CH_W-1:0] CHAR_LOWER_A   = 16'h0061;
   localparam logic [CH_W-1:0] CHAR_LOWER_Z   = 16'h007A;
   localparam logic [CH_W-1:0] CASE_OFFSET    = 16'h0020;

   // Register index, taken from paddr bit 2.
   localparam logic REG_MAX_PATH_LEN = 1'b0;

   typedef struct packed {
      logic [CH_W-1:0] ch;
      logic            no_char;
      logic            last;
   } item_type;

   function automatic logic in_charset(input logic [CH_W-1:0] c);
      return c inside {[16'h0041:16'h005A], [16'h0030:16'h0039],
                       16'h0024, 16'h0025, 16'h0027, 16'h002D, 16'h005F,
                       16'h0040, 16'h007E, 16'h0021, 16'h0023, 16'h0028,
                       16'h0029, 16'h007B, 16'h007D, 16'h005E};
   endfunction

endpackage

[src/snpv_if.sv]
// Valid/ready channel interfaces for the character words and the verdict words.
// Depends on snpv_pkg for field widths.
interface snpv_req_if;
   import snpv_pkg::*;
   logic            valid;
   logic            ready;
   logic [CH_W-1:0] ch;
   logic            no_char;
   logic            last;

   modport source (output valid, output ch, output no_char, output last, input ready);
   modport sink   (input valid, input ch, input no_char, input last, output ready);
endinterface

interface snpv_rsp_if;
   logic valid;
   logic ready;
   logic valid_res;

   modport source (output valid, output valid_res, input ready);
   modport sink   (input valid, input valid_res, output ready);
endinterface

[src/snpv_csr.sv]
// APB-style register block holding the maximum path length.
// Depends on snpv_pkg for widths, register index and reset value.
module snpv_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [snpv_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [snpv_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [snpv_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                             csr_pready,
   output logic [snpv_pkg::LEN_W-1:0]       max_len
);
   import snpv_pkg::*;

   logic [LEN_W-1:0] max_len_ff;
   logic [LEN_W-1:0] max_len_in;
   logic             reg_sel;
   logic             wr_en;

   assign reg_sel = (csr_paddr[2] == REG_MAX_PATH_LEN);
   assign wr_en   = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      max_len_in = max_len_ff;
      if (wr_en && reg_sel) begin
         max_len_in = csr_pwdata[LEN_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_ff <= MAX_LEN_RESET;
      end else begin
         max_len_ff <= max_len_in;
      end
   end

   assign csr_pready = 1'b1;
   assign csr_prdata = reg_sel ? {{(CSR_DATA_W-LEN_W){1'b0}}, max_len_ff} : '0;
   assign max_len    = max_len_ff;

endmodule

[src/snpv_path_core.sv]
// Per-path state (component counters, dot flag, sticky failure, length) and verdict logic.
// Depends on snpv_pkg for the word type, limits and character set.
module snpv_path_core (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        step,
   input  snpv_pkg::item_type          item,
   input  logic [snpv_pkg::LEN_W-1:0]  max_len,
   output logic                        verdict_ok
);
   import snpv_pkg::*;

   logic [BASE_W-1:0] base_ff, base_in, base_n;
   logic [EXT_W-1:0]  ext_ff, ext_in, ext_n;
   logic              dot_ff, dot_in, dot_n;
   logic              fail_ff, fail_in, fail_n;
   logic [LEN_W-1:0]  count_ff, count_in, count_n;
   logic [CH_W-1:0]   c_up;
   logic              open_ok, open_ok_n;

   assign open_ok = (base_ff != '0) && !(dot_ff && ext_ff == '0);

   always_comb begin
      base_n  = base_ff;
      ext_n   = ext_ff;
      dot_n   = dot_ff;
      fail_n  = fail_ff;
      count_n = count_ff;
      c_up    = item.ch;
      if (item.ch >= CHAR_LOWER_A && item.ch <= CHAR_LOWER_Z) begin
         c_up = item.ch - CASE_OFFSET;
      end
      if (!item.no_char) begin
         if (count_ff != COUNT_MAX) begin
            count_n = count_ff + 1'b1;
         end
         if (c_up == CHAR_BACKSLASH) begin
            // A separator closes the component, which must have been well formed.
            if (!open_ok) begin
               fail_n = 1'b1;
            end
            base_n = '0;
            ext_n  = '0;
            dot_n  = 1'b0;
         end else if (c_up == CHAR_DOT) begin
            if (dot_ff || base_ff == '0) begin
               fail_n = 1'b1;
            end
            dot_n = 1'b1;
         end else if (!in_charset(c_up)) begin
            fail_n = 1'b1;
         end else if (dot_ff) begin
            if (ext_ff == EXT_MAX) begin
               fail_n = 1'b1;
            end else begin
               ext_n = ext_ff + 1'b1;
            end
         end else begin
            if (base_ff >= BASE_MAX) begin
               fail_n = 1'b1;
            end else begin
               base_n = base_ff + 1'b1;
            end
         end
      end
   end

   assign open_ok_n  = (base_n != '0) && !(dot_n && ext_n == '0);
   assign verdict_ok = !fail_n && (count_n < max_len) && (count_n == '0 || open_ok_n);

   always_comb begin
      base_in  = base_ff;
      ext_in   = ext_ff;
      dot_in   = dot_ff;
      fail_in  = fail_ff;
      count_in = count_ff;
      if (step) begin
         if (item.last) begin
            base_in  = '0;
            ext_in   = '0;
            dot_in   = 1'b0;
            fail_in  = 1'b0;
            count_in = '0;
         end else begin
            base_in  = base_n;
            ext_in   = ext_n;
            dot_in   = dot_n;
            fail_in  = fail_n;
            count_in = count_n;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff  <= '0;
         ext_ff   <= '0;
         dot_ff   <= 1'b0;
         fail_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         base_ff  <= base_in;
         ext_ff   <= ext_in;
         dot_ff   <= dot_in;
         fail_ff  <= fail_in;
         count_ff <= count_in;
      end
   end

endmodule

[src/short_name_path_validator.sv]
// An accepted character word sits in the input register and updates the path counters
// when it steps on; a last-marked word then loads its verdict word into the result
// register, and stays in the input register while an unaccepted verdict word is held.
// Throughput: one word per cycle, but a last-marked word is held while the verdict before it is not taken.
// Reset: synchronous, active high; clears the path state and the valid flags of both stage
// registers, and sets the maximum path length to 64.
module short_name_path_validator (
   input  logic                             clock,
   input  logic                             reset,
   snpv_req_if.sink                         req_chan,
   snpv_rsp_if.source                       rsp_chan,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [snpv_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [snpv_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [snpv_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                             csr_pready
);
   import snpv_pkg::*;

   logic             in_valid_ff, in_valid_in;
   item_type         in_item_ff, in_item_in;
   logic             out_valid_ff, out_valid_in;
   logic             out_res_ff, out_res_in;
   logic             step;
   logic             verdict_ok;
   logic [LEN_W-1:0] max_len;

   snpv_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .max_len     (max_len)
   );

   snpv_path_core u_core (
      .clock      (clock),
      .reset      (reset),
      .step       (step),
      .item       (in_item_ff),
      .max_len    (max_len),
      .verdict_ok (verdict_ok)
   );

   // A word without last never needs the result register, so it moves on regardless.
   assign step = in_valid_ff && (!out_valid_ff || rsp_chan.ready || !in_item_ff.last);
   assign req_chan.ready = !in_valid_ff || step;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_item_in  = in_item_ff;
      if (req_chan.valid && req_chan.ready) begin
         in_valid_in        = 1'b1;
         in_item_in.ch      = req_chan.ch;
         in_item_in.no_char = req_chan.no_char;
         in_item_in.last    = req_chan.last;
      end else if (step) begin
         in_valid_in = 1'b0;
      end

      out_valid_in = out_valid_ff;
      out_res_in   = out_res_ff;
      if (step && in_item_ff.last) begin
         out_valid_in = 1'b1;
         out_res_in   = verdict_ok;
      end else if (rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
      in_item_ff <= in_item_in;
      out_res_ff <= out_res_in;
   end

   assign rsp_chan.valid     = out_valid_ff;
   assign rsp_chan.valid_res = out_res_ff;

endmodule

[src/snpv_checker.sv]
// Port-level assertions for the path validator and the bind that attaches them.
// Depends on snpv_pkg for the register index and widths.
module snpv_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_ready,
   input logic                             rsp_valid,
   input logic                             rsp_ready,
   input logic                             rsp_valid_res,
   input logic                             csr_psel,
   input logic                             csr_penable,
   input logic                             csr_pwrite,
   input logic [snpv_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input logic [snpv_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   input logic [snpv_pkg::CSR_DATA_W-1:0]  csr_prdata
);
   import snpv_pkg::*;

   // Both stage registers come out of reset empty.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid && req_ready)
      else $error("stage registers not empty after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_valid_res))
      else $error("stalled verdict word changed");

   // A written limit reads back on the next cycle.
   a_csr_readback: assert property (@(posedge clock) disable iff (reset)
      csr_psel && csr_penable && csr_pwrite && csr_paddr[2] == REG_MAX_PATH_LEN
      |=> csr_paddr[2] != REG_MAX_PATH_LEN ||
          csr_prdata[LEN_W-1:0] == $past(csr_pwdata[LEN_W-1:0]))
      else $error("max path length readback mismatch");

   // The input stage takes a word whenever no verdict is pending.
   a_ready_when_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid && !$past(rsp_valid) |-> req_ready || $past(req_ready))
      else $error("input stage blocked without a pending verdict");

endmodule

bind short_name_path_validator snpv_checker u_snpv_checker (
   .clock         (clock),
   .reset         (reset),
   .req_ready     (req_chan.ready),
   .rsp_valid     (rsp_chan.valid),
   .rsp_ready     (rsp_chan.ready),
   .rsp_valid_res (rsp_chan.valid_res),
   .csr_psel      (csr_psel),
   .csr_penable   (csr_penable),
   .csr_pwrite    (csr_pwrite),
   .csr_paddr     (csr_paddr),
   .csr_pwdata    (csr_pwdata),
   .csr_prdata    (csr_prdata)
);
